/* hdl/fste_pkg.sv */
package fste_pkg;

   // Segment bit positions inside one display word.
   localparam logic [14:0] SEG_A  = 15'h0001;
   localparam logic [14:0] SEG_B  = 15'h0002;
   localparam logic [14:0] SEG_C  = 15'h0004;
   localparam logic [14:0] SEG_D  = 15'h0008;
   localparam logic [14:0] SEG_E  = 15'h0010;
   localparam logic [14:0] SEG_F  = 15'h0020;
   localparam logic [14:0] SEG_G1 = 15'h0040;
   localparam logic [14:0] SEG_G2 = 15'h0080;
   localparam logic [14:0] SEG_H  = 15'h0100;
   localparam logic [14:0] SEG_I  = 15'h0200;
   localparam logic [14:0] SEG_J  = 15'h0400;
   localparam logic [14:0] SEG_K  = 15'h0800;
   localparam logic [14:0] SEG_L  = 15'h1000;
   localparam logic [14:0] SEG_M  = 15'h2000;
   localparam logic [14:0] SEG_DP = 15'h4000;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [4:0] DIGIT_CFG_RESET = 5'd4;

   // One display word as it moves from the front end to the output stage.
   typedef struct packed {
      logic        valid;
      logic        last;
      logic [14:0] seg;
   } fste_word_type;

   function automatic logic [14:0] fste_font(input logic [7:0] ch);
      logic [14:0] g;
      case (ch)
         "0":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         "1":  g = SEG_B | SEG_C;
         "2":  g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G1 | SEG_G2;
         "3":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G1 | SEG_G2;
         "4":  g = SEG_B | SEG_C | SEG_F | SEG_G1 | SEG_G2;
         "5":  g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G1 | SEG_G2;
         "6":  g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "7":  g = SEG_A | SEG_B | SEG_C;
         "8":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "9":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G1 | SEG_G2;
         "A":  g = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "B":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G2 | SEG_L | SEG_M;
         "C":  g = SEG_A | SEG_D | SEG_E | SEG_F;
         "D":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_L | SEG_M;
         "E":  g = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G1;
         "F":  g = SEG_A | SEG_E | SEG_F | SEG_G1;
         "G":  g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G2;
         "H":  g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "I":  g = SEG_A | SEG_D | SEG_L | SEG_M;
         "J":  g = SEG_B | SEG_C | SEG_D | SEG_E;
         "K":  g = SEG_E | SEG_F | SEG_G1 | SEG_I | SEG_J;
         "L":  g = SEG_D | SEG_E | SEG_F;
         "M":  g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_H | SEG_I;
         "N":  g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_H | SEG_J;
         "O":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         "P":  g = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "Q":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_J;
         "R":  g = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G1 | SEG_J;
         "S":  g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G1 | SEG_G2;
         "T":  g = SEG_A | SEG_L | SEG_M;
         "U":  g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         "V":  g = SEG_H | SEG_I;
         "W":  g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_J | SEG_K;
         "X":  g = SEG_H | SEG_I | SEG_J | SEG_K;
         "Y":  g = SEG_H | SEG_I | SEG_M;
         "Z":  g = SEG_A | SEG_D | SEG_I | SEG_K;
         "a":  g = SEG_D | SEG_E | SEG_G1 | SEG_M;
         "b":  g = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "c":  g = SEG_D | SEG_E | SEG_G1 | SEG_G2;
         "d":  g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G1 | SEG_G2;
         "e":  g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "f":  g = SEG_A | SEG_E | SEG_F | SEG_G1;
         "g":  g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G1 | SEG_G2;
         "h":  g = SEG_C | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "i":  g = SEG_M;
         "j":  g = SEG_B | SEG_C | SEG_D | SEG_E;
         "k":  g = SEG_E | SEG_F | SEG_G1 | SEG_I | SEG_J;
         "l":  g = SEG_L | SEG_M;
         "m":  g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_H | SEG_I;
         "n":  g = SEG_C | SEG_E | SEG_G1 | SEG_G2;
         "o":  g = SEG_C | SEG_D | SEG_E | SEG_G1 | SEG_G2;
         "p":  g = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G1 | SEG_G2;
         "q":  g = SEG_A | SEG_B | SEG_C | SEG_F | SEG_G1 | SEG_G2;
         "r":  g = SEG_E | SEG_G1;
         "s":  g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G1 | SEG_G2;
         "t":  g = SEG_D | SEG_E | SEG_F | SEG_G1;
         "u":  g = SEG_C | SEG_D | SEG_E;
         "v":  g = SEG_H | SEG_I;
         "w":  g = SEG_C | SEG_E | SEG_J | SEG_K;
         "x":  g = SEG_H | SEG_I | SEG_J | SEG_K;
         "y":  g = SEG_H | SEG_I | SEG_M;
         "z":  g = SEG_G1 | SEG_D | SEG_K;
         "-":  g = SEG_G1 | SEG_G2;
         "_":  g = SEG_D;
         "=":  g = SEG_D | SEG_G1 | SEG_G2;
         "*":  g = SEG_G1 | SEG_G2 | SEG_H | SEG_I | SEG_J | SEG_K | SEG_L | SEG_M;
         "/":  g = SEG_I | SEG_K;
         "\\": g = SEG_H | SEG_J;
         "+":  g = SEG_G1 | SEG_G2 | SEG_L | SEG_M;
         CHAR_SPACE: g = '0;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

/* hdl/fste_front.sv */
module fste_front #(
   parameter int MAX_DIGITS = 16,
   parameter int CW = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [4:0]             csr_data,
   input  logic                   req_tvalid,
   input  logic [7:0]             req_char,
   input  logic                   req_end,
   output logic                   req_tready,
   input  logic                   q_ready,
   output logic                   q_push,
   output fste_pkg::fste_word_type q_w0,
   output fste_pkg::fste_word_type q_w1,
   output logic [CW-1:0]          q_pad
);
   import fste_pkg::*;

   logic [4:0]    digit_cfg_ff;
   logic [14:0]   held_word_ff, held_word_in;
   logic          held_valid_ff, held_valid_in;
   logic [CW-1:0] digits_ff, digits_in;

   logic [CW-1:0] size;
   logic [CW-1:0] used, d1, d2;
   logic          is_dot, fits, accept;
   logic [14:0]   hw1;
   logic          hv1;

   always_comb begin
      if (digit_cfg_ff == 5'd0) begin
         size = CW'(1);
      end else if (int'(digit_cfg_ff) > MAX_DIGITS) begin
         size = CW'(MAX_DIGITS);
      end else begin
         size = CW'(digit_cfg_ff);
      end
   end

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   always_comb begin
      is_dot = (req_char == CHAR_DOT);
      used   = digits_ff + CW'(held_valid_ff);
      fits   = used < size;

      // A non-dot character always releases the held word, whether or not
      // it takes a digit itself.
      q_w0.valid = !is_dot && held_valid_ff;
      q_w0.seg   = held_word_ff;
      d1         = digits_ff + CW'(q_w0.valid);
      q_w0.last  = d1 >= size;

      if (is_dot) begin
         hv1 = held_valid_ff;
         hw1 = held_valid_ff ? (held_word_ff | SEG_DP) : held_word_ff;
      end else if (fits) begin
         hv1 = 1'b1;
         hw1 = fste_font(req_char);
      end else begin
         hv1 = 1'b0;
         hw1 = '0;
      end

      q_w1.valid = req_end && hv1;
      q_w1.seg   = hw1;
      d2         = d1 + CW'(q_w1.valid);
      q_w1.last  = d2 >= size;

      q_pad  = (req_end && (size > d2)) ? (size - d2) : '0;
      q_push = accept && (q_w0.valid || q_w1.valid || (q_pad != '0));

      if (req_end) begin
         held_word_in  = '0;
         held_valid_in = 1'b0;
         digits_in     = '0;
      end else begin
         held_word_in  = hw1;
         held_valid_in = hv1;
         digits_in     = d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_cfg_ff  <= DIGIT_CFG_RESET;
         held_word_ff  <= '0;
         held_valid_ff <= 1'b0;
         digits_ff     <= '0;
      end else begin
         if (csr_valid) begin
            digit_cfg_ff <= csr_data;
         end
         if (accept) begin
            held_word_ff  <= held_word_in;
            held_valid_ff <= held_valid_in;
            digits_ff     <= digits_in;
         end
      end
   end

endmodule

/* hdl/fste_queue.sv */
module fste_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             ready,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import fste_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff;

   assign ready      = count_ff != (PW+1)'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hdl/fste_back.sv */
module fste_back #(
   parameter int CW = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  fste_pkg::fste_word_type head_w0,
   input  fste_pkg::fste_word_type head_w1,
   input  logic [CW-1:0]           head_pad,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [14:0]             rsp_seg,
   output logic                    rsp_last
);
   import fste_pkg::*;

   logic          rsp_valid_ff;
   logic [14:0]   rsp_seg_ff, rsp_seg_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          done0_ff, done1_ff;
   logic [CW-1:0] pads_sent_ff;

   logic          emit, sel0, sel1, finish;
   logic [CW:0]   pads_next;

   assign emit      = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pads_next = {1'b0, pads_sent_ff} + 1'b1;

   always_comb begin
      sel0 = head_w0.valid && !done0_ff;
      sel1 = !sel0 && head_w1.valid && !done1_ff;
      if (sel0) begin
         rsp_seg_in  = head_w0.seg;
         rsp_last_in = head_w0.last;
         finish      = !head_w1.valid && (head_pad == '0);
      end else if (sel1) begin
         rsp_seg_in  = head_w1.seg;
         rsp_last_in = head_w1.last;
         finish      = head_pad == '0;
      end else begin
         // Padding blanks; only the one that reaches the group size is last.
         rsp_seg_in  = '0;
         rsp_last_in = pads_next == {1'b0, head_pad};
         finish      = rsp_last_in;
      end
   end

   assign pop        = emit && finish;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_seg    = rsp_seg_ff;
   assign rsp_last   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_seg_ff  <= rsp_seg_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done0_ff     <= 1'b0;
         done1_ff     <= 1'b0;
         pads_sent_ff <= '0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            done0_ff     <= 1'b0;
            done1_ff     <= 1'b0;
            pads_sent_ff <= '0;
         end else if (emit) begin
            if (sel0) begin
               done0_ff <= 1'b1;
            end else if (sel1) begin
               done1_ff <= 1'b1;
            end else begin
               pads_sent_ff <= pads_next[CW-1:0];
            end
         end
      end
   end

endmodule

/* hdl/fourteen_segment_text_encoder.sv */
// Channel   Ports             Payload
// -------   ---------------   -------------------------------------------------
// req       req_t*  (in)      tdata[7:0] character, tlast end_of_text
// rsp       rsp_t*  (out)     tdata[14:0] segments, tlast last_digit
// csr       csr_*   (in)      csr_data[4:0] display digits per string (reset 4)
//
// The front end takes one character per cycle while the queue has room and
// turns it into a command in a four-entry queue if it yields any word; the
// output stage sends one segment word per cycle unless rsp stalls. A character
// yields zero, one or two words, and the end of a string adds blank words up
// to the configured digit count. The first word a character releases passes
// through the queue and then the output register before it is offered on rsp.
// The input stalls only while four commands are waiting in the queue.
// Reset is synchronous and clears all control state; there is no clearing pass.
// Either side may stall: the queue and the output register absorb the slip.
module fourteen_segment_text_encoder #(
   parameter int MAX_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input characters. tdata: [7:0] character.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // Segment words. tdata: [14:0] segments, [15] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   // Digit count register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import fste_pkg::*;

   // Width of a digit count, able to hold MAX_DIGITS itself.
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int WW = $bits(fste_word_type);
   localparam int QW = 2 * WW + CW;

   fste_word_type f_w0, f_w1, h_w0, h_w1;
   logic [CW-1:0] f_pad, h_pad;
   logic          q_push, q_ready, q_pop, q_valid;
   logic [QW-1:0] q_in, q_out;
   logic [14:0]   seg;

   // The register may be written any time the block is idle.
   assign csr_ready = 1'b1;

   // The front end holds the newest glyph until the next character shows
   // whether a dot follows, and works out every word a character releases.
   fste_front #(
      .MAX_DIGITS(MAX_DIGITS),
      .CW        (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_char  (req_tdata),
      .req_end   (req_tlast),
      .req_tready(req_tready),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_w0      (f_w0),
      .q_w1      (f_w1),
      .q_pad     (f_pad)
   );

   assign q_in = {f_pad, f_w1, f_w0};

   fste_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .ready     (q_ready),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_data (q_out)
   );

   assign h_w0  = q_out[WW-1:0];
   assign h_w1  = q_out[2*WW-1:WW];
   assign h_pad = q_out[QW-1:2*WW];

   // The output stage plays each command out word by word.
   fste_back #(
      .CW(CW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(q_valid),
      .head_w0   (h_w0),
      .head_w1   (h_w1),
      .head_pad  (h_pad),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_seg   (seg),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, seg};

   // A command is never written into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> q_ready)
      else $error("command pushed into a full queue");

   // A command is popped with its last word, never while rsp is stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !q_pop)
      else $error("queue popped while the output is stalled");

   // A new word appears at the output only if a command was waiting.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_valid))
      else $error("output word without a queued command");

endmodule
